// ===== sv/isq_pkg.sv =====
// Shared types and codes for the indexed sequence store.
package isq_pkg;

	localparam int OP_W   = 3;
	localparam int POS_W  = 8;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 9;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;

	localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_SET    = 3'd2;
	localparam logic [OP_W-1:0] OP_READ   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SHIFT
	} isq_state_t;

endpackage

// ===== sv/indexed_sequence_store.sv =====
// Indexed sequence store: position-addressed word list in one synchronous memory.
// Timing: append, set, clear, unused codes and out-of-range requests register their word
//   the cycle after accept; an in-range read passes the memory read register, then the
//   output register, and holds off input meanwhile; remove at position p moves the words
//   above p down in the one-word-per-cycle shift loop (only the length drops for the last).
// Throughput: single-access operations accept a word every cycle while results drain.
// Reset (arst_n low, asynchronous): length 0, FSM idle, no result pending; memory not cleared.
module indexed_sequence_store #(
	parameter int CAPACITY = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [isq_pkg::IN_DATA_W-1:0]     s_tdata,  // [7:0] position, [39:8] write_value
	input  logic [isq_pkg::OP_W-1:0]          s_tuser,  // [2:0] operation
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [isq_pkg::OUT_DATA_W-1:0]    m_tdata,  // [31:0] read_value,
	                                                    // [40:32] current_length, [47:41] zero
	output logic [isq_pkg::STAT_W-1:0]        m_tuser   // [1:0] status
);
	import isq_pkg::*;

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	// compare width: holds count, position, and pointer + 2 without wrap
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	// storage and state
	logic [WORD_W-1:0] mem_q [CAPACITY];
	logic [WORD_W-1:0] rd_data_s1;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] ptr_q;      // shift loop: entry being written
	isq_state_t        state_q, state_d;

	// output register
	logic              m_tvalid_q;
	logic [WORD_W-1:0] out_rd_q;
	logic [STAT_W-1:0] out_st_q;
	logic [LEN_W-1:0]  out_len_q;

	// input word fields
	logic [OP_W-1:0]   in_op;
	logic [POS_W-1:0]  in_pos;
	logic [WORD_W-1:0] in_val;
	logic              accept;

	logic [CMP_W-1:0]  pos_ext, cnt_ext, ptr_ext;
	logic [CMP_W-1:0]  pos_next;   // position + 1
	logic [CMP_W-1:0]  ptr_ahead;  // pointer + 2
	logic              in_range;   // position below length
	logic              pos_tail;   // a word exists above position
	logic              shift_more; // another word left to move down
	logic              full;

	// control from the datapath block
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              out_load;
	logic [WORD_W-1:0] out_rd_d;
	logic [STAT_W-1:0] out_st_d;
	logic [CNT_W-1:0]  count_d;
	logic [ADDR_W-1:0] ptr_d;

	assign in_op  = s_tuser;
	assign in_pos = s_tdata[POS_W-1:0];
	assign in_val = s_tdata[POS_W +: WORD_W];

	// one item in flight; take the next once the result slot is free or draining
	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	assign pos_ext    = CMP_W'(in_pos);
	assign cnt_ext    = CMP_W'(count_q);
	assign ptr_ext    = CMP_W'(ptr_q);
	assign pos_next   = pos_ext + CMP_W'(1);
	assign ptr_ahead  = ptr_ext + CMP_W'(2);
	assign in_range   = pos_ext < cnt_ext;
	assign pos_tail   = pos_next < cnt_ext;
	assign shift_more = ptr_ahead < cnt_ext;
	assign full       = count_q == CNT_W'(CAPACITY);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && in_range) begin
					if (in_op == OP_READ) begin
						state_d = S_READ;
					end else if (in_op == OP_REMOVE && pos_tail) begin
						state_d = S_SHIFT;
					end
				end
			end
			S_READ: begin
				state_d = S_IDLE;
			end
			S_SHIFT: begin
				if (!shift_more) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// memory access, length update and result
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		out_load  = 1'b0;
		out_rd_d  = '0;
		out_st_d  = ST_OK;
		count_d   = count_q;
		ptr_d     = ptr_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_op)
						OP_APPEND: begin
							out_load = 1'b1;
							if (full) begin
								out_st_d = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = count_q[ADDR_W-1:0];
								mem_wdata = in_val;
								count_d   = count_q + CNT_W'(1);
							end
						end
						OP_REMOVE: begin
							if (!in_range) begin
								out_load = 1'b1;
								out_st_d = ST_RANGE;
							end else if (pos_tail) begin
								// prime the shift: fetch the word above
								mem_re    = 1'b1;
								mem_raddr = pos_next[ADDR_W-1:0];
								ptr_d     = pos_ext[ADDR_W-1:0];
							end else begin
								// last word: only the length drops
								out_load = 1'b1;
								count_d  = count_q - CNT_W'(1);
							end
						end
						OP_SET: begin
							out_load = 1'b1;
							if (in_range) begin
								mem_we    = 1'b1;
								mem_waddr = pos_ext[ADDR_W-1:0];
								mem_wdata = in_val;
							end else begin
								out_st_d = ST_RANGE;
							end
						end
						OP_READ: begin
							if (in_range) begin
								mem_re    = 1'b1;
								mem_raddr = pos_ext[ADDR_W-1:0];
							end else begin
								out_load = 1'b1;
								out_st_d = ST_RANGE;
							end
						end
						OP_CLEAR: begin
							out_load = 1'b1;
							count_d  = '0;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				out_load = 1'b1;
				out_rd_d = rd_data_s1;
			end
			S_SHIFT: begin
				// move word ptr+1 (now in rd_data) down; reads run ahead of writes
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = rd_data_s1;
				if (shift_more) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_ahead[ADDR_W-1:0];
					ptr_d     = ptr_q + ADDR_W'(1);
				end else begin
					out_load = 1'b1;
					count_d  = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// word memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		if (out_load) begin
			out_rd_q  <= out_rd_d;
			out_st_q  <= out_st_d;
			out_len_q <= LEN_W'(count_d);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_DATA_W - WORD_W - LEN_W)'(0), out_len_q, out_rd_q};
	assign m_tuser  = out_st_q;

endmodule

// ===== sv/isq_checker.sv =====
// Port-level checks for the indexed sequence store, bound to the top level.
module isq_checker #(
	parameter int CAPACITY = 256
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [isq_pkg::IN_DATA_W-1:0]     s_tdata,
	input logic [isq_pkg::OP_W-1:0]          s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [isq_pkg::OUT_DATA_W-1:0]    m_tdata,
	input logic [isq_pkg::STAT_W-1:0]        m_tuser
);
	import isq_pkg::*;

	localparam int CAP_CLIP = (CAPACITY > 256) ? 256 : CAPACITY;

	// a pending, stalled result blocks new words
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while result stalled");

	// failed operations return zero data
	a_fail_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[WORD_W-1:0] == '0))
		else $error("nonzero read_value with error status");

	// length never passes capacity, and full only at capacity
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (CAPACITY > 256) ||
			((m_tdata[WORD_W +: LEN_W] <= LEN_W'(CAP_CLIP)) &&
			 ((m_tuser != ST_FULL) || (m_tdata[WORD_W +: LEN_W] == LEN_W'(CAP_CLIP)))))
		else $error("length out of bounds");

	// stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind indexed_sequence_store isq_checker #(.CAPACITY(CAPACITY)) u_isq_checker (.*);
